// ===== hdl/euf_pkg.sv =====
// euf_pkg: types, constants and saturating helpers for the euler flux core
// used by every module under hdl; no dependencies
package euf_pkg;

	localparam int DATA_WIDTH    = 32;
	localparam int FRAC_BITS_DEF = 16;
	localparam int GM1_WIDTH     = 18;
	localparam logic [GM1_WIDTH-1:0] GM1_RESET = 18'd26214;
	localparam int QUEUE_DEPTH   = 4;

	typedef logic signed [DATA_WIDTH-1:0] word_t;
	typedef logic [DATA_WIDTH-1:0] mag_t;
	typedef logic [2*DATA_WIDTH-1:0] wide_t;

	localparam word_t MAXV = {1'b0, {(DATA_WIDTH-1){1'b1}}};
	localparam word_t MINV = {1'b1, {(DATA_WIDTH-1){1'b0}}};
	localparam wide_t MAXW = {{(DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};

	typedef struct packed {
		word_t density;
		word_t mom_x;
		word_t mom_y;
		word_t mom_z;
		word_t energy;
	} cell_t;

	typedef struct packed {
		word_t fx_mass;
		word_t fx_momx;
		word_t fx_momy;
		word_t fx_momz;
		word_t fx_energy;
		word_t gy_mass;
		word_t gy_momx;
		word_t gy_momy;
		word_t gy_momz;
		word_t gy_energy;
		logic  bad_density;
	} flux_t;

	typedef struct packed {
		logic  bad;
		cell_t cons;
	} qitem_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	function automatic word_t sat_add(word_t a, word_t b);
		logic signed [DATA_WIDTH:0] s;
		s = {a[DATA_WIDTH-1], a} + {b[DATA_WIDTH-1], b};
		if (s[DATA_WIDTH] != s[DATA_WIDTH-1])
			return s[DATA_WIDTH] ? MINV : MAXV;
		return s[DATA_WIDTH-1:0];
	endfunction

	function automatic word_t sat_sub(word_t a, word_t b);
		logic signed [DATA_WIDTH:0] s;
		s = {a[DATA_WIDTH-1], a} - {b[DATA_WIDTH-1], b};
		if (s[DATA_WIDTH] != s[DATA_WIDTH-1])
			return s[DATA_WIDTH] ? MINV : MAXV;
		return s[DATA_WIDTH-1:0];
	endfunction

	// halve, truncating toward zero
	function automatic word_t half(word_t a);
		word_t t;
		t = a + word_t'({{(DATA_WIDTH-1){1'b0}}, a[DATA_WIDTH-1]});
		return t >>> 1;
	endfunction

	function automatic mag_t mag(word_t a);
		return a[DATA_WIDTH-1] ? mag_t'(-a) : mag_t'(a);
	endfunction

	function automatic word_t sat_mag(logic neg, wide_t m);
		if (m > MAXW)
			return neg ? MINV : MAXV;
		return neg ? -$signed(m[DATA_WIDTH-1:0]) : $signed(m[DATA_WIDTH-1:0]);
	endfunction

endpackage

// ===== hdl/euf_front.sv =====
// euf_front: input register that takes cells and flags non-positive density
// depends on euf_pkg; feeds euf_queue
module euf_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cell_valid,
	output logic             cell_ready,
	input  euf_pkg::cell_t   cell_data,
	input  euf_pkg::qstat_t  qstat,
	output logic             push,
	output euf_pkg::qitem_t  qitem
);

	logic            valid_q;
	euf_pkg::qitem_t item_q;

	assign cell_ready = !valid_q || !qstat.full;
	assign push       = valid_q;
	assign qitem      = item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cell_ready) begin
			valid_q <= cell_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cell_ready && cell_valid) begin
			item_q <= '{bad: cell_data.density[euf_pkg::DATA_WIDTH-1] ||
				(cell_data.density == '0), cons: cell_data};
		end
	end

endmodule

// ===== hdl/euf_queue.sv =====
// euf_queue: short register queue between front and back
// depends on euf_pkg
module euf_queue #(
	parameter int DEPTH = euf_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  euf_pkg::qitem_t  din,
	input  logic             pop,
	output euf_pkg::qitem_t  dout,
	output euf_pkg::qstat_t  qstat
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	euf_pkg::qitem_t mem_q [DEPTH];
	logic [AW-1:0]   wr_q, rd_q;
	logic [CW-1:0]   cnt_q;
	logic            do_push, do_pop;

	assign qstat.full  = (cnt_q == CW'(DEPTH));
	assign qstat.empty = (cnt_q == '0);
	assign do_push     = push && !qstat.full;
	assign do_pop      = pop && !qstat.empty;
	assign dout        = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (do_pop)
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_q] <= din;
	end

endmodule

// ===== hdl/euf_back.sv =====
// euf_back: pipelined divider, multipliers and saturation for the fluxes
// depends on euf_pkg; pops from euf_queue
module euf_back #(
	parameter int FRAC_BITS = euf_pkg::FRAC_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  euf_pkg::qitem_t                 head,
	input  euf_pkg::qstat_t                 qstat,
	output logic                            pop,
	input  logic [euf_pkg::GM1_WIDTH-1:0]   gm1,
	output logic                            flux_valid,
	input  logic                            flux_ready,
	output euf_pkg::flux_t                  flux
);

	localparam int DW = euf_pkg::DATA_WIDTH;
	localparam int QW = DW + FRAC_BITS;
	localparam int NS = QW;

	typedef struct packed {
		logic           bad;
		euf_pkg::word_t mx, my, mz, en;
		euf_pkg::word_t u, v, w;
		euf_pkg::word_t a, b, c, d, e, f, g;
		euf_pkg::word_t ab, ke, diff, p, ep, r1, r7;
	} carry_t;

	function automatic euf_pkg::wide_t umul(euf_pkg::mag_t x, euf_pkg::mag_t y);
		return (2*DW)'(x) * (2*DW)'(y);
	endfunction

	logic adv;

	// divider pipeline, three lanes sharing the density divisor
	logic                   dv_valid_s [NS+1];
	euf_pkg::qitem_t        dv_item_s  [NS+1];
	logic [QW-1:0]          dv_n_s     [NS+1][3];
	logic [QW-1:0]          dv_q_s     [NS+1][3];
	logic [DW-2:0]          dv_rem_s   [NS+1][3];

	assign adv = !flux_valid || flux_ready;
	assign pop = adv && !qstat.empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			dv_valid_s[0] <= 1'b0;
		else if (adv)
			dv_valid_s[0] <= !qstat.empty;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dv_item_s[0] <= head;
			dv_n_s[0][0] <= {euf_pkg::mag(head.cons.mom_x), {FRAC_BITS{1'b0}}};
			dv_n_s[0][1] <= {euf_pkg::mag(head.cons.mom_y), {FRAC_BITS{1'b0}}};
			dv_n_s[0][2] <= {euf_pkg::mag(head.cons.mom_z), {FRAC_BITS{1'b0}}};
			for (int l = 0; l < 3; l++) begin
				dv_q_s[0][l]   <= '0;
				dv_rem_s[0][l] <= '0;
			end
		end
	end

	for (genvar k = 1; k <= NS; k++) begin : g_div
		logic [DW-1:0] r2 [3];
		logic          ge [3];
		always_comb begin
			for (int l = 0; l < 3; l++) begin
				r2[l] = {dv_rem_s[k-1][l], dv_n_s[k-1][l][QW-1]};
				ge[l] = r2[l] >= $unsigned(dv_item_s[k-1].cons.density);
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				dv_valid_s[k] <= 1'b0;
			else if (adv)
				dv_valid_s[k] <= dv_valid_s[k-1];
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				dv_item_s[k] <= dv_item_s[k-1];
				for (int l = 0; l < 3; l++) begin
					dv_n_s[k][l]   <= dv_n_s[k-1][l] << 1;
					dv_q_s[k][l]   <= {dv_q_s[k-1][l][QW-2:0], ge[l]};
					dv_rem_s[k][l] <= (DW-1)'(ge[l]
						? r2[l] - $unsigned(dv_item_s[k-1].cons.density) : r2[l]);
				end
			end
		end
	end

	// arithmetic stages after the divider
	logic   vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9, vld_s10;
	carry_t cr_s1, cr_s2, cr_s3, cr_s4, cr_s5, cr_s6, cr_s7, cr_s8, cr_s9, cr_s10;
	carry_t nx_s1, nx_s3, nx_s4, nx_s5, nx_s6, nx_s8, nx_s9;
	euf_pkg::flux_t nx_flux;
	euf_pkg::wide_t pm_s2 [7];
	logic           ng_s2 [7];
	euf_pkg::wide_t pg_s7;
	logic           ngp_s7;
	euf_pkg::wide_t pe_s10 [2];
	logic           nge_s10 [2];
	euf_pkg::cell_t dc;

	assign dc = dv_item_s[NS].cons;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{vld_s1, vld_s2, vld_s3, vld_s4, vld_s5} <= '0;
			{vld_s6, vld_s7, vld_s8, vld_s9, vld_s10} <= '0;
			flux_valid <= 1'b0;
		end else if (adv) begin
			vld_s1  <= dv_valid_s[NS];
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			vld_s5  <= vld_s4;
			vld_s6  <= vld_s5;
			vld_s7  <= vld_s6;
			vld_s8  <= vld_s7;
			vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;
			flux_valid <= vld_s10;
		end
	end

	always_comb begin
		nx_s1     = '0;
		nx_s1.bad = dv_item_s[NS].bad;
		nx_s1.mx  = dc.mom_x;
		nx_s1.my  = dc.mom_y;
		nx_s1.mz  = dc.mom_z;
		nx_s1.en  = dc.energy;
		nx_s1.u   = euf_pkg::sat_mag(dc.mom_x[DW-1], (2*DW)'(dv_q_s[NS][0]));
		nx_s1.v   = euf_pkg::sat_mag(dc.mom_y[DW-1], (2*DW)'(dv_q_s[NS][1]));
		nx_s1.w   = euf_pkg::sat_mag(dc.mom_z[DW-1], (2*DW)'(dv_q_s[NS][2]));

		nx_s3   = cr_s2;
		nx_s3.a = euf_pkg::sat_mag(ng_s2[0], pm_s2[0] >> FRAC_BITS);
		nx_s3.b = euf_pkg::sat_mag(ng_s2[1], pm_s2[1] >> FRAC_BITS);
		nx_s3.c = euf_pkg::sat_mag(ng_s2[2], pm_s2[2] >> FRAC_BITS);
		nx_s3.d = euf_pkg::sat_mag(ng_s2[3], pm_s2[3] >> FRAC_BITS);
		nx_s3.e = euf_pkg::sat_mag(ng_s2[4], pm_s2[4] >> FRAC_BITS);
		nx_s3.f = euf_pkg::sat_mag(ng_s2[5], pm_s2[5] >> FRAC_BITS);
		nx_s3.g = euf_pkg::sat_mag(ng_s2[6], pm_s2[6] >> FRAC_BITS);

		nx_s4    = cr_s3;
		nx_s4.ab = euf_pkg::sat_add(cr_s3.a, cr_s3.b);

		nx_s5    = cr_s4;
		nx_s5.ke = euf_pkg::half(euf_pkg::sat_add(cr_s4.ab, cr_s4.c));

		nx_s6      = cr_s5;
		nx_s6.diff = euf_pkg::sat_sub(cr_s5.en, cr_s5.ke);

		nx_s8   = cr_s7;
		nx_s8.p = euf_pkg::sat_mag(ngp_s7, pg_s7 >> FRAC_BITS);

		nx_s9    = cr_s8;
		nx_s9.ep = euf_pkg::sat_add(cr_s8.en, cr_s8.p);
		nx_s9.r1 = euf_pkg::sat_add(cr_s8.a, cr_s8.p);
		nx_s9.r7 = euf_pkg::sat_add(cr_s8.b, cr_s8.p);

		nx_flux = '0;
		if (cr_s10.bad) begin
			nx_flux.bad_density = 1'b1;
		end else begin
			nx_flux.fx_mass   = cr_s10.mx;
			nx_flux.fx_momx   = cr_s10.r1;
			nx_flux.fx_momy   = cr_s10.d;
			nx_flux.fx_momz   = cr_s10.e;
			nx_flux.fx_energy = euf_pkg::sat_mag(nge_s10[0], pe_s10[0] >> FRAC_BITS);
			nx_flux.gy_mass   = cr_s10.my;
			nx_flux.gy_momx   = cr_s10.f;
			nx_flux.gy_momy   = cr_s10.r7;
			nx_flux.gy_momz   = cr_s10.g;
			nx_flux.gy_energy = euf_pkg::sat_mag(nge_s10[1], pe_s10[1] >> FRAC_BITS);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cr_s1 <= nx_s1;

			cr_s2 <= cr_s1;
			pm_s2[0] <= umul(euf_pkg::mag(cr_s1.mx), euf_pkg::mag(cr_s1.u));
			pm_s2[1] <= umul(euf_pkg::mag(cr_s1.my), euf_pkg::mag(cr_s1.v));
			pm_s2[2] <= umul(euf_pkg::mag(cr_s1.mz), euf_pkg::mag(cr_s1.w));
			pm_s2[3] <= umul(euf_pkg::mag(cr_s1.my), euf_pkg::mag(cr_s1.u));
			pm_s2[4] <= umul(euf_pkg::mag(cr_s1.mz), euf_pkg::mag(cr_s1.u));
			pm_s2[5] <= umul(euf_pkg::mag(cr_s1.mx), euf_pkg::mag(cr_s1.v));
			pm_s2[6] <= umul(euf_pkg::mag(cr_s1.mz), euf_pkg::mag(cr_s1.v));
			ng_s2[0] <= cr_s1.mx[DW-1] ^ cr_s1.u[DW-1];
			ng_s2[1] <= cr_s1.my[DW-1] ^ cr_s1.v[DW-1];
			ng_s2[2] <= cr_s1.mz[DW-1] ^ cr_s1.w[DW-1];
			ng_s2[3] <= cr_s1.my[DW-1] ^ cr_s1.u[DW-1];
			ng_s2[4] <= cr_s1.mz[DW-1] ^ cr_s1.u[DW-1];
			ng_s2[5] <= cr_s1.mx[DW-1] ^ cr_s1.v[DW-1];
			ng_s2[6] <= cr_s1.mz[DW-1] ^ cr_s1.v[DW-1];

			cr_s3 <= nx_s3;
			cr_s4 <= nx_s4;
			cr_s5 <= nx_s5;
			cr_s6 <= nx_s6;

			cr_s7  <= cr_s6;
			pg_s7  <= (2*DW)'(gm1) * (2*DW)'(euf_pkg::mag(cr_s6.diff));
			ngp_s7 <= cr_s6.diff[DW-1];

			cr_s8 <= nx_s8;
			cr_s9 <= nx_s9;

			cr_s10     <= cr_s9;
			pe_s10[0]  <= umul(euf_pkg::mag(cr_s9.u), euf_pkg::mag(cr_s9.ep));
			pe_s10[1]  <= umul(euf_pkg::mag(cr_s9.v), euf_pkg::mag(cr_s9.ep));
			nge_s10[0] <= cr_s9.u[DW-1] ^ cr_s9.ep[DW-1];
			nge_s10[1] <= cr_s9.v[DW-1] ^ cr_s9.ep[DW-1];

			flux <= nx_flux;
		end
	end

endmodule

// ===== hdl/euler_flux_2d_core.sv =====
// euler_flux_2d_core: top level of the compressible euler flux block
// depends on euf_pkg, euf_front, euf_queue, euf_back
//
//  channel  handshake               payload
//  cell     cell_valid/cell_ready   cell_data (density, mom_x, mom_y, mom_z, energy)
//  flux     flux_valid/flux_ready   flux (x and y fluxes, bad_density)
//  cfg      cfg_we                  cfg_wdata (gamma_minus_one)
//
// one item per cycle sustained while flux_ready is held high; the path from a taken
// item to flux_valid runs through the front register, the queue, the
// bit-per-stage divider and the multiply and saturate stages
// arst_n clears all valid state and loads gamma_minus_one with its default
// a stalled flux output freezes the back pipeline; the queue then absorbs items
module euler_flux_2d_core #(
	parameter int FRAC_BITS = euf_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [euf_pkg::GM1_WIDTH-1:0] cfg_wdata,
	input  logic                          cell_valid,
	output logic                          cell_ready,
	input  euf_pkg::cell_t                cell_data,
	output logic                          flux_valid,
	input  logic                          flux_ready,
	output euf_pkg::flux_t                flux
);

	logic [euf_pkg::GM1_WIDTH-1:0] gm1_q;
	logic            q_push, q_pop;
	euf_pkg::qitem_t q_in, q_head;
	euf_pkg::qstat_t q_stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			gm1_q <= euf_pkg::GM1_RESET;
		else if (cfg_we)
			gm1_q <= cfg_wdata;
	end

	euf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cell_valid (cell_valid),
		.cell_ready (cell_ready),
		.cell_data  (cell_data),
		.qstat      (q_stat),
		.push       (q_push),
		.qitem      (q_in)
	);

	euf_queue #(.DEPTH(euf_pkg::QUEUE_DEPTH)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (q_in),
		.pop    (q_pop),
		.dout   (q_head),
		.qstat  (q_stat)
	);

	euf_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (q_head),
		.qstat      (q_stat),
		.pop        (q_pop),
		.gm1        (gm1_q),
		.flux_valid (flux_valid),
		.flux_ready (flux_ready),
		.flux       (flux)
	);

`ifndef SYNTHESIS
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		flux_valid && flux.bad_density |->
			flux.fx_mass == '0 && flux.fx_momx == '0 && flux.fx_momy == '0 &&
			flux.fx_momz == '0 && flux.fx_energy == '0 && flux.gy_mass == '0 &&
			flux.gy_momx == '0 && flux.gy_momy == '0 && flux.gy_momz == '0 &&
			flux.gy_energy == '0)
		else $error("bad density item carries non-zero flux");

	a_front_hold: assert property (@(posedge clk) disable iff (!arst_n)
		q_push && q_stat.full |=> q_push && $stable(q_in))
		else $error("front dropped or changed an item while queue full");

	a_queue_stat: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_stat.full && q_stat.empty))
		else $error("queue reports full and empty together");
`endif

endmodule

// ===== test/testbench.sv =====
// testbench: streams cells into euler_flux_2d_core and checks every flux item
// against an in-bench saturating fixed-point model of the euler fluxes
// depends on euf_pkg and the core rtl under hdl
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import euf_pkg::*;

	localparam int LATENCY = DATA_WIDTH + FRAC_BITS_DEF + 13;
	localparam longint LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [GM1_WIDTH-1:0] cfg_wdata = '0;
	logic cell_valid = 1'b0;
	logic cell_ready;
	cell_t cell_data = '0;
	logic flux_valid;
	logic flux_ready = 1'b0;
	flux_t flux;

	euler_flux_2d_core dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.cell_valid(cell_valid), .cell_ready(cell_ready), .cell_data(cell_data),
		.flux_valid(flux_valid), .flux_ready(flux_ready), .flux(flux)
	);

	always #4 clk = ~clk;

	cell_t pending_cells[$];
	flux_t expected_fluxes[$];
	logic [GM1_WIDTH-1:0] gm1;
	int errors = 0;
	int gap = 0;
	int stall = 0;
	longint cycles = 0;

	localparam longint WMAX = 64'sd2147483647;
	localparam longint WMIN = -64'sd2147483648;

	function automatic longint clamp(longint a);
		if (a > WMAX) return WMAX;
		if (a < WMIN) return WMIN;
		return a;
	endfunction

	// exact 128-bit product, truncated toward zero, then saturated
	function automatic longint qmul(longint a, longint b);
		logic signed [127:0] p;
		logic [127:0] m;
		logic neg;
		p = 128'(signed'(a)) * 128'(signed'(b));
		neg = p[127];
		m = neg ? -p : p;
		m = m >> FRAC_BITS_DEF;
		if (m > 128'(WMAX)) return neg ? WMIN : WMAX;
		return neg ? -longint'(m) : longint'(m);
	endfunction

	function automatic longint qdiv(longint a, longint d);
		logic signed [127:0] n;
		logic signed [127:0] q;
		n = 128'(signed'(a)) <<< FRAC_BITS_DEF;
		q = n / 128'(signed'(d));
		if (q > 128'(WMAX)) return WMAX;
		if (q < 128'(signed'(WMIN))) return WMIN;
		return longint'(q);
	endfunction

	function automatic flux_t euler_flux(cell_t c, logic [GM1_WIDTH-1:0] g);
		flux_t f;
		longint rho, mx, my, mz, en, u, v, w, ke, p, ep;
		f = '0;
		rho = c.density; mx = c.mom_x; my = c.mom_y; mz = c.mom_z; en = c.energy;
		if (rho <= 0) begin
			f.bad_density = 1'b1;
			return f;
		end
		u = qdiv(mx, rho);
		v = qdiv(my, rho);
		w = qdiv(mz, rho);
		ke = clamp(clamp(qmul(mx, u) + qmul(my, v)) + qmul(mz, w)) / 2;
		p = qmul(longint'(g), clamp(en - ke));
		ep = clamp(en + p);
		f.fx_mass = word_t'(mx);
		f.fx_momx = word_t'(clamp(qmul(mx, u) + p));
		f.fx_momy = word_t'(qmul(my, u));
		f.fx_momz = word_t'(qmul(mz, u));
		f.fx_energy = word_t'(qmul(u, ep));
		f.gy_mass = word_t'(my);
		f.gy_momx = word_t'(qmul(mx, v));
		f.gy_momy = word_t'(clamp(qmul(my, v) + p));
		f.gy_momz = word_t'(qmul(mz, v));
		f.gy_energy = word_t'(qmul(v, ep));
		return f;
	endfunction

	task automatic report_mismatch(string what, flux_t got, flux_t want);
		errors++;
		$display("mismatch %s: got %h expected %h", what, got, want);
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// driver
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cell_valid && cell_ready) begin
			expected_fluxes.push_back(euler_flux(cell_data, gm1));
		end
		if (!cell_valid || cell_ready) begin
			if (gap > 0) begin
				gap <= gap - 1;
				cell_valid <= 1'b0;
			end else if (pending_cells.size() > 0) begin
				cell_data <= pending_cells.pop_front();
				cell_valid <= 1'b1;
				gap <= pick_gap();
			end else begin
				cell_valid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (flux_valid && flux_ready) begin
			if (expected_fluxes.size() == 0) begin
				report_mismatch("unexpected", flux, '0);
			end else begin
				flux_t want;
				want = expected_fluxes.pop_front();
				if (flux.fx_mass !== want.fx_mass) report_mismatch("fx_mass", flux, want);
				if (flux.fx_momx !== want.fx_momx) report_mismatch("fx_momx", flux, want);
				if (flux.fx_momy !== want.fx_momy) report_mismatch("fx_momy", flux, want);
				if (flux.fx_momz !== want.fx_momz) report_mismatch("fx_momz", flux, want);
				if (flux.fx_energy !== want.fx_energy)
					report_mismatch("fx_energy", flux, want);
				if (flux.gy_mass !== want.gy_mass) report_mismatch("gy_mass", flux, want);
				if (flux.gy_momx !== want.gy_momx) report_mismatch("gy_momx", flux, want);
				if (flux.gy_momy !== want.gy_momy) report_mismatch("gy_momy", flux, want);
				if (flux.gy_momz !== want.gy_momz) report_mismatch("gy_momz", flux, want);
				if (flux.gy_energy !== want.gy_energy)
					report_mismatch("gy_energy", flux, want);
				if (flux.bad_density !== want.bad_density)
					report_mismatch("bad_density", flux, want);
			end
		end
		if (stall > 0) begin
			stall <= stall - 1;
			flux_ready <= 1'b0;
		end else begin
			stall <= pick_gap();
			flux_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (cycles > LIMIT) begin
			$display("testbench NOT OK");
			$finish;
		end
	end

	function automatic word_t rand_word();
		case ($urandom_range(0, 5))
			0: return word_t'($urandom);
			1: return word_t'($urandom_range(0, 32'h0004_0000)) - word_t'(32'h0002_0000);
			2: return word_t'($urandom_range(0, 32'h0100_0000)) - word_t'(32'h0080_0000);
			3: return MAXV - word_t'($urandom_range(0, 3));
			4: return MINV + word_t'($urandom_range(0, 3));
			default: return word_t'($urandom_range(0, 32'h0000_4000));
		endcase
	endfunction

	function automatic cell_t rand_cell();
		cell_t c;
		c.density = ($urandom_range(0, 9) == 0) ? rand_word()
			: word_t'($urandom_range(1, 32'h0008_0000));
		if ($urandom_range(0, 7) == 0) c.density = word_t'($urandom);
		c.mom_x = rand_word();
		c.mom_y = rand_word();
		c.mom_z = rand_word();
		c.energy = ($urandom_range(0, 2) == 0) ? rand_word()
			: word_t'($urandom_range(0, 32'h0040_0000));
		return c;
	endfunction

	task automatic add_cell(word_t d, word_t x, word_t y, word_t z, word_t e);
		cell_t c;
		c.density = d; c.mom_x = x; c.mom_y = y; c.mom_z = z; c.energy = e;
		pending_cells.push_back(c);
	endtask

	task automatic drain();
		while (pending_cells.size() > 0 || cell_valid || expected_fluxes.size() > 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic write_gm1(logic [GM1_WIDTH-1:0] g);
		cfg_wdata <= g;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		gm1 = g;
		@(posedge clk);
	endtask

	initial begin
		logic [GM1_WIDTH-1:0] settings[5];
		gm1 = GM1_RESET;
		settings = '{18'd0, 18'h3FFFF, 18'd131072, 18'd26214, 18'd0};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: bad density, extremes, saturation
		add_cell(32'h0001_0000, 32'h0002_0000, 32'hFFFF_0000, 32'h0000_8000, 32'h0010_0000);
		add_cell('0, 32'h1234_5678, 32'h1, 32'h2, 32'h3);
		add_cell(MINV, MAXV, MINV, MAXV, MINV);
		add_cell(32'hFFFF_FFFF, 32'h1, 32'h1, 32'h1, 32'h1);
		add_cell(32'h1, MAXV, MINV, MAXV, MAXV);
		add_cell(32'h1, MINV, MAXV, MINV, MINV);
		add_cell(MAXV, MAXV, MAXV, MAXV, MAXV);
		add_cell(MAXV, MINV, MINV, MINV, MINV);
		add_cell(32'h0001_0000, '0, '0, '0, '0);
		add_cell(32'h0000_0100, 32'h0100_0000, 32'h0100_0000, 32'h0100_0000, MINV);
		add_cell(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, MAXV);
		add_cell(32'h0000_8000, 32'hFFFF_8000, 32'h0000_8000, 32'hFFFF_FFFF, 32'h0000_0001);
		drain();
		for (int s = 0; s < 5; s++) begin
			write_gm1(settings[s] & ((s == 1) ? 18'h3FFFF : 18'h3FFFF));
			if (s == 4) write_gm1(GM1_WIDTH'($urandom));
			for (int i = 0; i < 350; i++) pending_cells.push_back(rand_cell());
			drain();
		end
		if (errors == 0) begin
			$display("testbench OK");
		end else begin
			$display("testbench NOT OK");
		end
		$finish;
	end
endmodule
